// ===== hdl/cslr_pkg.sv =====
// cslr_pkg: shared types, codes and constants of the console serial line registers
// used by cslr_exec, console_serial_line_registers and cslr_checker
package cslr_pkg;

  // bus command codes, carried in tuser
  typedef enum logic [2:0] {
    CMD_RD_WORD   = 3'd0,
    CMD_RD_BYTE   = 3'd1,
    CMD_WR_WORD   = 3'd2,
    CMD_WR_BYTE   = 3'd3,
    CMD_RX_NOTIFY = 3'd4
  } cmd_e;

  // register indexes (byte offset bits 2:1)
  localparam logic [1:0] REG_TKS = 2'd0;
  localparam logic [1:0] REG_TKB = 2'd1;
  localparam logic [1:0] REG_TPS = 2'd2;
  localparam logic [1:0] REG_TPB = 2'd3;

  localparam int unsigned NumRegs  = 4;
  localparam int unsigned BitReady = 7;
  localparam int unsigned BitIe    = 6;

  // interrupt vectors
  localparam logic [5:0] VEC_NONE = 6'o00;
  localparam logic [5:0] VEC_RX   = 6'o60;
  localparam logic [5:0] VEC_TX   = 6'o64;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 32;

  typedef logic [NumRegs-1:0][15:0] regfile_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  byte_offset;
    logic [15:0] write_data;
    logic        rx_pending;
    logic        rx_char_valid;
    logic [6:0]  rx_char;
    logic        rx_more;
  } item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        tx_valid;
    logic [6:0]  tx_char;
    logic        irq_request;
    logic [5:0]  irq_vector;
  } result_t;

  // even parity over seven data bits
  function automatic logic parity7(input logic [6:0] c);
    parity7 = ^c;
  endfunction

endpackage

// ===== hdl/cslr_exec.sv =====
// cslr_exec: single-pass execution of one bus access or receive notify on the register file
// depends on cslr_pkg
module cslr_exec (
  input  cslr_pkg::item_t    item_i,
  input  cslr_pkg::regfile_t regs_i,
  output cslr_pkg::regfile_t regs_o,
  output cslr_pkg::result_t  res_o
);

  logic [1:0]  sel;
  logic        even;
  logic [15:0] v;
  logic [15:0] w;
  logic        more;

  assign sel  = item_i.byte_offset[2:1];
  assign even = ~item_i.byte_offset[0];

  always_comb begin
    regs_o = regs_i;
    res_o  = '0;
    v      = regs_i[sel];
    w      = item_i.write_data;
    more   = 1'b0;
    case (item_i.cmd)
      cslr_pkg::CMD_RD_WORD, cslr_pkg::CMD_RD_BYTE: begin
        // byte reads always go through the even address
        if (even || (item_i.cmd == cslr_pkg::CMD_RD_BYTE)) begin
          case (sel)
            cslr_pkg::REG_TKS: begin
              v[cslr_pkg::BitReady] = item_i.rx_pending;
            end
            cslr_pkg::REG_TKB: begin
              if (item_i.rx_char_valid) begin
                v    = {8'h00, cslr_pkg::parity7(item_i.rx_char), item_i.rx_char};
                more = item_i.rx_more;
              end else begin
                v = '0;
              end
            end
            cslr_pkg::REG_TPS: begin
              v[cslr_pkg::BitReady] = 1'b1;
            end
            default: begin
            end
          endcase
        end
        regs_o[sel] = v;
        if (more) begin
          regs_o[cslr_pkg::REG_TKS][cslr_pkg::BitReady] = 1'b1;
          if (regs_i[cslr_pkg::REG_TKS][cslr_pkg::BitIe]) begin
            res_o.irq_request = 1'b1;
            res_o.irq_vector  = cslr_pkg::VEC_RX;
          end
        end
        if (item_i.cmd == cslr_pkg::CMD_RD_BYTE) begin
          res_o.read_data = item_i.byte_offset[0] ? {8'h00, v[15:8]} : {8'h00, v[7:0]};
        end else begin
          res_o.read_data = v;
        end
      end
      cslr_pkg::CMD_WR_WORD, cslr_pkg::CMD_WR_BYTE: begin
        if (item_i.cmd == cslr_pkg::CMD_WR_BYTE) begin
          w = item_i.byte_offset[0] ? {item_i.write_data[7:0], regs_i[sel][7:0]}
                                    : {regs_i[sel][15:8], item_i.write_data[7:0]};
        end
        regs_o[sel] = w;
        if (even && (sel == cslr_pkg::REG_TPB)) begin
          res_o.tx_valid = 1'b1;
          res_o.tx_char  = w[6:0];
          regs_o[cslr_pkg::REG_TPS][cslr_pkg::BitReady] = 1'b1;
          if (regs_i[cslr_pkg::REG_TPS][cslr_pkg::BitIe]) begin
            res_o.irq_request = 1'b1;
            res_o.irq_vector  = cslr_pkg::VEC_TX;
          end
        end
      end
      cslr_pkg::CMD_RX_NOTIFY: begin
        regs_o[cslr_pkg::REG_TKS][cslr_pkg::BitReady] = 1'b1;
        if (regs_i[cslr_pkg::REG_TKS][cslr_pkg::BitIe]) begin
          res_o.irq_request = 1'b1;
          res_o.irq_vector  = cslr_pkg::VEC_RX;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/console_serial_line_registers.sv =====
// console_serial_line_registers: top level of the console serial line register block
// depends on cslr_pkg and cslr_exec
//
// Four 16-bit device registers of a console serial line: receiver status (offset 0),
// receiver buffer (offset 2), transmitter status (offset 4) and transmitter buffer
// (offset 6). Each input item is one bus access (word or byte read or write) or a
// receive notify from the console, selected by s_axis_tuser. Every item yields
// exactly one result item with the read data, any transmitted character and any
// interrupt request (vector 060 receive, 064 transmit). The block takes one
// item per clock cycle when the output side keeps up; an item passes from the input
// register into the result register, which drives the result port and holds the
// result until it is taken. The register file is updated as an item moves from the
// input register to the result register, so back-to-back accesses see each other's
// effects.
// Reset clears all four registers.
module console_serial_line_registers (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: byte_offset[2:0], write_data[18:3], rx_pending[19], rx_char_valid[20],
  //        rx_char[27:21], rx_more[28], zero[31:29]
  input  logic [cslr_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: cmd[2:0]
  input  logic [2:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: read_data[15:0], tx_valid[16], tx_char[23:17], irq_request[24],
  //        irq_vector[30:25], zero[31]
  output logic [cslr_pkg::OutDataW-1:0] m_axis_tdata
);

  // input register
  logic              in_valid_q;
  cslr_pkg::item_t   in_item_q;
  cslr_pkg::item_t   in_item_d;

  // result register
  logic              out_valid_q;
  cslr_pkg::result_t out_res_q;
  cslr_pkg::result_t res_d;

  // device registers
  cslr_pkg::regfile_t regs_q;
  cslr_pkg::regfile_t regs_d;

  logic advance;

  // item moves on when the result register is empty or being drained
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;

  // unpack the slave-side item
  always_comb begin
    in_item_d.cmd           = s_axis_tuser;
    in_item_d.byte_offset   = s_axis_tdata[2:0];
    in_item_d.write_data    = s_axis_tdata[18:3];
    in_item_d.rx_pending    = s_axis_tdata[19];
    in_item_d.rx_char_valid = s_axis_tdata[20];
    in_item_d.rx_char       = s_axis_tdata[27:21];
    in_item_d.rx_more       = s_axis_tdata[28];
  end

  cslr_exec u_exec (
    .item_i (in_item_q),
    .regs_i (regs_q),
    .regs_o (regs_d),
    .res_o  (res_d)
  );

  // control and register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      regs_q      <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        regs_q      <= regs_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q <= in_item_d;
    end
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_res_q.irq_vector, out_res_q.irq_request,
                          out_res_q.tx_char, out_res_q.tx_valid, out_res_q.read_data};

endmodule

// ===== hdl/cslr_checker.sv =====
// cslr_checker: port-level assertions for console_serial_line_registers
// depends on cslr_pkg; bound to the top level below
module cslr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [cslr_pkg::OutDataW-1:0] m_axis_tdata
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // vector is zero without a request, otherwise receive or transmit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[24] ? (m_axis_tdata[30:25] == cslr_pkg::VEC_RX ||
                                           m_axis_tdata[30:25] == cslr_pkg::VEC_TX)
                                        : (m_axis_tdata[30:25] == cslr_pkg::VEC_NONE)))
    else $error("bad interrupt vector");

  // no character without tx_valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[16] |-> m_axis_tdata[23:17] == 7'd0)
    else $error("tx_char set without tx_valid");

  // a transmit can only raise the transmit vector
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[16] && m_axis_tdata[24] |->
      m_axis_tdata[30:25] == cslr_pkg::VEC_TX)
    else $error("transmit with receive vector");

  // transmits return no read data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tdata[15:0] == 16'd0)
    else $error("read data on a transmit");

endmodule

bind console_serial_line_registers cslr_checker u_cslr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb_console_serial_line_registers.sv =====
`timescale 1ns / 1ps
// tb_console_serial_line_registers: self-checking testbench for the console serial line registers
// depends on cslr_pkg and console_serial_line_registers; predicts each response in order
module tb_console_serial_line_registers;

  localparam int unsigned MaxShownErrors = 10;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  // tdata: byte_offset, write_data, rx_pending, rx_char_valid, rx_char, rx_more, zero
  logic [cslr_pkg::InDataW-1:0]  s_axis_tdata;
  // tuser: cmd
  logic [2:0]                    s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  // tdata: read_data, tx_valid, tx_char, irq_request, irq_vector, zero
  logic [cslr_pkg::OutDataW-1:0] m_axis_tdata;

  // shadow copy of the four device registers
  logic [15:0]       line_regs [cslr_pkg::NumRegs];
  // responses predicted for accepted items, oldest first
  cslr_pkg::result_t due_responses [$];
  int unsigned       error_count = 0;
  bit                gaps_on = 1'b0;
  int unsigned       sink_hold = 0;

  console_serial_line_registers DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // console has a character: receiver ready, receive interrupt when enabled
  function automatic void raise_rx_ready(inout cslr_pkg::result_t r);
    line_regs[cslr_pkg::REG_TKS][cslr_pkg::BitReady] = 1'b1;
    if (line_regs[cslr_pkg::REG_TKS][cslr_pkg::BitIe]) begin
      r.irq_request = 1'b1;
      r.irq_vector  = cslr_pkg::VEC_RX;
    end
  endfunction

  // word read with the side effects of the even addresses
  function automatic logic [15:0] read_reg(input logic [2:0] offset,
                                           input cslr_pkg::item_t it,
                                           inout cslr_pkg::result_t r);
    logic [1:0]  idx;
    logic [15:0] w;
    logic        more;
    idx  = offset[2:1];
    w    = line_regs[idx];
    more = 1'b0;
    if (!offset[0]) begin
      case (idx)
        cslr_pkg::REG_TKS: begin
          w[cslr_pkg::BitReady] = it.rx_pending;
        end
        cslr_pkg::REG_TKB: begin
          if (it.rx_char_valid) begin
            // parity bit above the seven data bits
            w    = {8'h00, ^it.rx_char, it.rx_char};
            more = it.rx_more;
          end else begin
            w = '0;
          end
        end
        cslr_pkg::REG_TPS: begin
          w[cslr_pkg::BitReady] = 1'b1;
        end
        default: begin
        end
      endcase
    end
    line_regs[idx] = w;
    if (more) raise_rx_ready(r);
    return w;
  endfunction

  // word write; the even transmitter buffer address sends a character
  function automatic void write_reg(input logic [2:0] offset, input logic [15:0] w,
                                    inout cslr_pkg::result_t r);
    logic [1:0] idx;
    idx = offset[2:1];
    if (!offset[0] && idx == cslr_pkg::REG_TPB) begin
      r.tx_valid = 1'b1;
      r.tx_char  = w[6:0];
      line_regs[cslr_pkg::REG_TPS][cslr_pkg::BitReady] = 1'b1;
      if (line_regs[cslr_pkg::REG_TPS][cslr_pkg::BitIe]) begin
        r.irq_request = 1'b1;
        r.irq_vector  = cslr_pkg::VEC_TX;
      end
    end
    line_regs[idx] = w;
  endfunction

  function automatic cslr_pkg::result_t predict_bus_access(input cslr_pkg::item_t it);
    cslr_pkg::result_t r;
    logic [15:0]       w;
    r = '0;
    case (it.cmd)
      cslr_pkg::CMD_RD_WORD: begin
        w = read_reg(it.byte_offset, it, r);
        r.read_data = w;
      end
      cslr_pkg::CMD_RD_BYTE: begin
        // byte read acts as a read of the even address
        w = read_reg({it.byte_offset[2:1], 1'b0}, it, r);
        r.read_data = it.byte_offset[0] ? {8'h00, w[15:8]} : {8'h00, w[7:0]};
      end
      cslr_pkg::CMD_WR_WORD: begin
        write_reg(it.byte_offset, it.write_data, r);
      end
      cslr_pkg::CMD_WR_BYTE: begin
        w = line_regs[it.byte_offset[2:1]];
        if (it.byte_offset[0]) w[15:8] = it.write_data[7:0];
        else w[7:0] = it.write_data[7:0];
        write_reg(it.byte_offset, w, r);
      end
      cslr_pkg::CMD_RX_NOTIFY: begin
        raise_rx_ready(r);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic cslr_pkg::item_t make_access(input cslr_pkg::cmd_e cmd,
                                                  input logic [2:0] offset,
                                                  input logic [15:0] data = '0,
                                                  input logic pending = 1'b0,
                                                  input logic valid = 1'b0,
                                                  input logic [6:0] ch = '0,
                                                  input logic more = 1'b0);
    cslr_pkg::item_t it;
    it.cmd           = cmd;
    it.byte_offset   = offset;
    it.write_data    = data;
    it.rx_pending    = pending;
    it.rx_char_valid = valid;
    it.rx_char       = ch;
    it.rx_more       = more;
    return it;
  endfunction

  function automatic cslr_pkg::item_t random_access();
    cslr_pkg::item_t it;
    it.cmd           = 3'($urandom_range(cslr_pkg::CMD_RX_NOTIFY));
    it.byte_offset   = 3'($urandom_range(7));
    it.write_data    = 16'($urandom);
    it.rx_pending    = 1'($urandom);
    it.rx_char_valid = 1'($urandom);
    it.rx_char       = 7'($urandom);
    it.rx_more       = 1'($urandom);
    return it;
  endfunction

  // entered just after a falling edge; leaves tvalid high for the next item
  task automatic send_access(input cslr_pkg::item_t it);
    if (gaps_on && $urandom_range(5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.cmd;
    s_axis_tdata  <= {3'b000, it.rx_more, it.rx_char, it.rx_char_valid, it.rx_pending,
                      it.write_data, it.byte_offset};
    do @(posedge clk_i); while (!s_axis_tready);
    due_responses.push_back(predict_bus_access(it));
    @(negedge clk_i);
  endtask

  task automatic wait_responses_drained();
    s_axis_tvalid <= 1'b0;
    while (due_responses.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // registers read back as zero but for status: receiver picks up the pending flag, transmitter reads ready
  task automatic test_reset_state();
    send_access(make_access(cslr_pkg::CMD_RD_WORD, 3'd0, '0, 1'b1));
    send_access(make_access(cslr_pkg::CMD_RD_WORD, 3'd2));
    send_access(make_access(cslr_pkg::CMD_RD_WORD, 3'd4));
    send_access(make_access(cslr_pkg::CMD_RD_WORD, 3'd6));
  endtask

  task automatic test_receive_path();
    send_access(make_access(cslr_pkg::CMD_WR_WORD, 3'd0, 16'hffff));
    send_access(make_access(cslr_pkg::CMD_RX_NOTIFY, 3'd0));
    // all-ones character with more waiting raises the receive interrupt
    send_access(make_access(cslr_pkg::CMD_RD_WORD, 3'd2, '0, 1'b0, 1'b1, 7'h7f, 1'b1));
    send_access(make_access(cslr_pkg::CMD_RD_WORD, 3'd2, '0, 1'b0, 1'b1, 7'h01, 1'b0));
    send_access(make_access(cslr_pkg::CMD_RD_WORD, 3'd2, '0, 1'b1, 1'b0, 7'h7f, 1'b1));
    send_access(make_access(cslr_pkg::CMD_RD_BYTE, 3'd3, '0, 1'b0, 1'b1, 7'h55, 1'b1));
    send_access(make_access(cslr_pkg::CMD_WR_WORD, 3'd0, 16'h0000));
    send_access(make_access(cslr_pkg::CMD_RX_NOTIFY, 3'd5, 16'hffff));
    send_access(make_access(cslr_pkg::CMD_RD_WORD, 3'd0));
  endtask

  task automatic test_transmit_path();
    send_access(make_access(cslr_pkg::CMD_WR_WORD, 3'd4, 16'h0040));
    send_access(make_access(cslr_pkg::CMD_RD_WORD, 3'd4));
    send_access(make_access(cslr_pkg::CMD_WR_WORD, 3'd6, 16'hffff));
    send_access(make_access(cslr_pkg::CMD_WR_BYTE, 3'd6, 16'hff00));
    send_access(make_access(cslr_pkg::CMD_WR_BYTE, 3'd7, 16'h00ab));
    send_access(make_access(cslr_pkg::CMD_WR_WORD, 3'd4, 16'h0000));
    send_access(make_access(cslr_pkg::CMD_WR_WORD, 3'd6, 16'h0041));
  endtask

  // odd addresses give raw register access without side effects, except byte reads, which act as even reads
  task automatic test_odd_offsets();
    send_access(make_access(cslr_pkg::CMD_RD_WORD, 3'd1, '0, 1'b1));
    send_access(make_access(cslr_pkg::CMD_RD_WORD, 3'd5));
    send_access(make_access(cslr_pkg::CMD_RD_WORD, 3'd7));
    send_access(make_access(cslr_pkg::CMD_WR_WORD, 3'd7, 16'h8000));
    send_access(make_access(cslr_pkg::CMD_WR_WORD, 3'd1, 16'h00c0));
    send_access(make_access(cslr_pkg::CMD_RD_BYTE, 3'd5));
    send_access(make_access(cslr_pkg::CMD_RD_BYTE, 3'd0, '0, 1'b1));
    send_access(make_access(cslr_pkg::CMD_WR_BYTE, 3'd1, 16'h0040));
  endtask

  task automatic test_random_traffic(input int unsigned count);
    repeat (count) send_access(random_access());
  endtask

  // output side: random stall bursts while gaps are on
  always @(negedge clk_i) begin
    if (gaps_on && sink_hold != 0) begin
      sink_hold = sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(7) == 0) begin
      sink_hold = $urandom_range(16);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_responses
    cslr_pkg::result_t seen;
    cslr_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.read_data   = m_axis_tdata[15:0];
      seen.tx_valid    = m_axis_tdata[16];
      seen.tx_char     = m_axis_tdata[23:17];
      seen.irq_request = m_axis_tdata[24];
      seen.irq_vector  = m_axis_tdata[30:25];
      if (due_responses.size() == 0) begin
        error_count++;
        if (error_count <= MaxShownErrors)
          $display("unexpected response tdata=%h", m_axis_tdata);
      end else begin
        want = due_responses.pop_front();
        if (seen !== want) begin
          error_count++;
          if (error_count <= MaxShownErrors)
            $display({"mismatch: expected rd=%h tx=%b ch=%h irq=%b vec=%o, ",
                      "got rd=%h tx=%b ch=%h irq=%b vec=%o"},
                     want.read_data, want.tx_valid, want.tx_char, want.irq_request,
                     want.irq_vector, seen.read_data, seen.tx_valid, seen.tx_char,
                     seen.irq_request, seen.irq_vector);
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = cslr_pkg::CMD_RD_WORD;
    foreach (line_regs[i]) line_regs[i] = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni  = 1'b1;
    gaps_on = 1'b1;
    @(negedge clk_i);
    test_reset_state();
    test_receive_path();
    test_transmit_path();
    test_odd_offsets();
    test_random_traffic(300);
    // hold the sender until the block has answered everything
    wait_responses_drained();
    test_random_traffic(280);
    gaps_on = 1'b0;
    test_random_traffic(70);
    wait_responses_drained();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_console_serial_line_registers OK");
    end else begin
      $display("tb_console_serial_line_registers NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_console_serial_line_registers NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/cslr_pkg.sv
hdl/cslr_exec.sv
hdl/console_serial_line_registers.sv
hdl/cslr_checker.sv
tb/tb_console_serial_line_registers.sv
